@@ src/lrk_pkg.sv @@
`timescale 1ns / 1ps
package lrk_pkg;

  typedef enum logic [3:0] {
    K_NOP, K_FX, K_FY, K_XY, K_BZ, K_SX, K_SY, K_SZ,
    K_GX, K_GY, K_GZ, K_DX, K_DY, K_DZ, K_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     half;
    logic     dbl;
  } op_t;

  localparam int PROG_LEN = 35;
  localparam int PC_BITS  = 6;

  localparam op_t PROG [PROG_LEN] = '{
    '{K_FX, 1'b0, 1'b0}, '{K_FY, 1'b0, 1'b0}, '{K_XY, 1'b0, 1'b0}, '{K_BZ, 1'b0, 1'b0},
    '{K_SX, 1'b1, 1'b0}, '{K_SY, 1'b1, 1'b0}, '{K_SZ, 1'b1, 1'b0}, '{K_NOP, 1'b0, 1'b0},
    '{K_FX, 1'b0, 1'b1}, '{K_FY, 1'b0, 1'b1}, '{K_XY, 1'b0, 1'b1}, '{K_BZ, 1'b0, 1'b1},
    '{K_SX, 1'b1, 1'b1}, '{K_SY, 1'b1, 1'b1}, '{K_SZ, 1'b1, 1'b1}, '{K_NOP, 1'b0, 1'b0},
    '{K_FX, 1'b0, 1'b1}, '{K_FY, 1'b0, 1'b1}, '{K_XY, 1'b0, 1'b1}, '{K_BZ, 1'b0, 1'b1},
    '{K_SX, 1'b0, 1'b1}, '{K_SY, 1'b0, 1'b1}, '{K_SZ, 1'b0, 1'b1}, '{K_NOP, 1'b0, 1'b0},
    '{K_FX, 1'b0, 1'b0}, '{K_FY, 1'b0, 1'b0}, '{K_XY, 1'b0, 1'b0}, '{K_BZ, 1'b0, 1'b0},
    '{K_GX, 1'b0, 1'b0}, '{K_GY, 1'b0, 1'b0}, '{K_GZ, 1'b0, 1'b0},
    '{K_DX, 1'b0, 1'b0}, '{K_DY, 1'b0, 1'b0}, '{K_DZ, 1'b0, 1'b0},
    '{K_END, 1'b0, 1'b0}
  };

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIVWAIT, S_FIN} state_t;

  localparam int CFG_IDX_BITS = 3;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STEP_SIZE, REG_SIGMA, REG_RHO, REG_BETA, REG_START_X, REG_START_Y, REG_START_Z
  } reg_idx_t;

  // product magnitude limit and rounded product width
  localparam int LIM_SHIFT = 60;
  localparam int QW        = 62;

  // divide by three, one digit per cycle
  localparam int DIV_BITS  = 60;
  localparam int DIG_BITS  = 6;
  localparam int DIG_COUNT = 10;
  localparam int CNT_BITS  = 4;
  localparam int RCP       = 171;
  localparam int RCP_BITS  = 8;
  localparam int RCP_SH    = 9;

  typedef struct packed {
    logic accept;
    logic restart;
    op_t  op;
    logic div_start;
    logic pos_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

endpackage

@@ src/lrk_if.sv @@
`timescale 1ns / 1ps
interface lrk_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface lrk_rsp_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] point_x;
  logic signed [WORD_BITS-1:0] point_y;
  logic signed [WORD_BITS-1:0] point_z;
  logic                        saturated;
  modport source (output valid, output point_x, output point_y, output point_z,
                  output saturated, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input saturated, output ready);
endinterface

interface lrk_cfg_if #(parameter int WORD_BITS = 32);
  logic                              valid;
  logic                              ready;
  logic [lrk_pkg::CFG_IDX_BITS-1:0] index;
  logic [WORD_BITS-1:0]              data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/lrk_div3.sv @@
`timescale 1ns / 1ps
module lrk_div3 (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lrk_pkg::DIV_BITS-1:0] dividend,
  output logic                         busy,
  output logic [lrk_pkg::DIV_BITS-1:0] quotient
);
  localparam int VW = lrk_pkg::DIG_BITS + 2;
  localparam int MW = VW + lrk_pkg::RCP_BITS;

  logic [lrk_pkg::DIV_BITS-1:0] num;
  logic [lrk_pkg::DIV_BITS-1:0] quo;
  logic [1:0]                   rem;
  logic [lrk_pkg::CNT_BITS-1:0] cnt;
  logic [VW-1:0]                v;
  logic [MW-1:0]                mprod;
  logic [lrk_pkg::DIG_BITS-1:0] qd;
  logic [VW-1:0]                r;

  always_comb begin
    v     = {rem, num[lrk_pkg::DIV_BITS-1 -: lrk_pkg::DIG_BITS]};
    mprod = MW'(v) * MW'(lrk_pkg::RCP);
    qd    = mprod[lrk_pkg::RCP_SH +: lrk_pkg::DIG_BITS];
    r     = v - {2'b00, qd} - {1'b0, qd, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      num  <= dividend;
      rem  <= 2'b00;
    end else if (busy) begin
      num <= num << lrk_pkg::DIG_BITS;
      quo <= {quo[lrk_pkg::DIV_BITS-lrk_pkg::DIG_BITS-1:0], qd};
      rem <= r[1:0];
      cnt <= cnt + 1'b1;
      if (cnt == lrk_pkg::CNT_BITS'(lrk_pkg::DIG_COUNT - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;

endmodule

@@ src/lrk_dp.sv @@
`timescale 1ns / 1ps
module lrk_dp #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 22
) (
  input  logic                             clk,
  input  logic                             rst,
  input  lrk_pkg::cmd_t                    cmd,
  output lrk_pkg::status_t                 status,
  input  logic                             cfg_we,
  input  logic [lrk_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]             cfg_data,
  output logic signed [WORD_BITS-1:0]      point_x,
  output logic signed [WORD_BITS-1:0]      point_y,
  output logic signed [WORD_BITS-1:0]      point_z,
  output logic                             saturated
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int QW = lrk_pkg::QW;
  localparam int AW = W + 3;
  localparam int BW = (W + 1 > F + 2) ? W + 1 : F + 2;
  localparam int PW = AW + BW;
  localparam int RW = (PW + 1 > QW) ? PW + 1 : QW;
  localparam int SW = QW + 1;

  localparam longint ONE  = longint'(1) <<< F;
  localparam longint WMAX = (longint'(1) <<< (W - 1)) - 1;
  localparam longint HMAX = (longint'(1) <<< (F + 1)) - 1;

  function automatic longint clip_c(input longint v, input longint hi);
    return (v > hi) ? hi : v;
  endfunction

  localparam longint RST_H     = clip_c((ONE + 50) / 100, HMAX);
  localparam longint RST_SIGMA = clip_c(10 * ONE, WMAX);
  localparam longint RST_RHO   = clip_c((996 * ONE + 5) / 10, WMAX);
  localparam longint RST_BETA  = clip_c((8 * ONE + 1) / 3, WMAX);
  localparam longint RST_X     = clip_c(ONE, WMAX);
  localparam longint RST_Y     = clip_c(2 * ONE, WMAX);
  localparam longint RST_Z     = clip_c(3 * ONE, WMAX);

  localparam logic signed [SW-1:0] SMAX = SW'(WMAX);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
  localparam logic [RW-1:0]        LIM  = RW'(1) << lrk_pkg::LIM_SHIFT;

  function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] v);
    if (v > SMAX) return W'(SMAX);
    if (v < SMIN) return W'(SMIN);
    return W'(v);
  endfunction

  logic [F:0]                h;
  logic [W-2:0]              sigma, rho, beta;
  logic signed [W-1:0]       sx, sy, sz;
  logic signed [W-1:0]       px, py, pz;
  logic signed [W-1:0]       ex, ey, ez;
  logic signed [W-1:0]       kx, ky, kz;
  logic signed [W-1:0]       cx, cy, cz;
  logic signed [AW-1:0]      acc_x, acc_y, acc_z;
  logic signed [QW-1:0]      t, mx, my, mz;
  lrk_pkg::op_t              op1, op2;
  logic signed [PW-1:0]      prod;
  logic signed [QW-1:0]      q;
  logic                      flag;

  logic signed [AW-1:0]      a;
  logic signed [BW-1:0]      b;
  logic signed [RW-1:0]      pext;
  logic                      neg;
  logic [RW-1:0]             mag, rnd, qmag;
  logic                      mclip;
  logic signed [QW-1:0]      q_next;
  logic signed [SW-1:0]      wb_v;
  logic                      wb_chk, wb_ovf;
  logic signed [W-1:0]       wb_s;
  logic signed [QW-1:0]      m_sel;
  logic signed [W-1:0]       p_sel;
  logic [QW-1:0]             dmag;
  logic [lrk_pkg::DIV_BITS-1:0] div_in, quotient;
  logic signed [SW-1:0]      fin_q, fin_v;
  logic                      fin_ovf;
  logic signed [W-1:0]       fin_s;
  logic                      div_busy;

  // operand select for the shared multiplier
  always_comb begin
    a = '0;
    b = '0;
    case (cmd.op.kind)
      lrk_pkg::K_FX: begin
        a = AW'(signed'({1'b0, sigma}));
        b = BW'(ey) - BW'(ex);
      end
      lrk_pkg::K_FY: begin
        a = AW'(ex);
        b = BW'(signed'({1'b0, rho})) - BW'(ez);
      end
      lrk_pkg::K_XY: begin
        a = AW'(ex);
        b = BW'(ey);
      end
      lrk_pkg::K_BZ: begin
        a = AW'(signed'({1'b0, beta}));
        b = BW'(ez);
      end
      lrk_pkg::K_SX: begin
        a = AW'(kx);
        b = BW'(signed'({1'b0, h}));
      end
      lrk_pkg::K_SY: begin
        a = AW'(ky);
        b = BW'(signed'({1'b0, h}));
      end
      lrk_pkg::K_SZ: begin
        a = AW'(kz);
        b = BW'(signed'({1'b0, h}));
      end
      lrk_pkg::K_GX: begin
        a = acc_x + AW'(kx);
        b = BW'(signed'({1'b0, h}));
      end
      lrk_pkg::K_GY: begin
        a = acc_y + AW'(ky);
        b = BW'(signed'({1'b0, h}));
      end
      lrk_pkg::K_GZ: begin
        a = acc_z + AW'(kz);
        b = BW'(signed'({1'b0, h}));
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  // rounding, ties away from zero, with magnitude clip
  always_comb begin
    neg  = prod[PW-1];
    pext = RW'(prod);
    mag  = neg ? -pext : pext;
    if (op1.half) begin
      rnd = (mag + (RW'(1) << F)) >> (F + 1);
    end else begin
      rnd = (mag + (RW'(1) << (F - 1))) >> F;
    end
    mclip  = rnd > LIM;
    qmag   = mclip ? LIM : rnd;
    q_next = neg ? -signed'(QW'(qmag)) : signed'(QW'(qmag));
  end

  // writeback arithmetic
  always_comb begin
    wb_v   = '0;
    wb_chk = 1'b0;
    case (op2.kind)
      lrk_pkg::K_FX: begin
        wb_v   = SW'(q);
        wb_chk = 1'b1;
      end
      lrk_pkg::K_FY: begin
        wb_v   = SW'(q) - SW'(ey);
        wb_chk = 1'b1;
      end
      lrk_pkg::K_BZ: begin
        wb_v   = SW'(t) - SW'(q);
        wb_chk = 1'b1;
      end
      lrk_pkg::K_SX: begin
        wb_v   = SW'(px) + SW'(q);
        wb_chk = 1'b1;
      end
      lrk_pkg::K_SY: begin
        wb_v   = SW'(py) + SW'(q);
        wb_chk = 1'b1;
      end
      lrk_pkg::K_SZ: begin
        wb_v   = SW'(pz) + SW'(q);
        wb_chk = 1'b1;
      end
      default: begin
        wb_v   = '0;
        wb_chk = 1'b0;
      end
    endcase
    wb_s   = sat(wb_v);
    wb_ovf = wb_chk && (wb_v > SMAX || wb_v < SMIN);
  end

  // final divide by six and update
  always_comb begin
    case (cmd.op.kind)
      lrk_pkg::K_DY: begin
        m_sel = my;
        p_sel = py;
      end
      lrk_pkg::K_DZ: begin
        m_sel = mz;
        p_sel = pz;
      end
      default: begin
        m_sel = mx;
        p_sel = px;
      end
    endcase
    dmag    = (m_sel[QW-1] ? -m_sel : m_sel) + QW'(3);
    div_in  = lrk_pkg::DIV_BITS'(dmag >> 1);
    fin_q   = SW'(signed'({1'b0, quotient}));
    fin_v   = SW'(p_sel) + (m_sel[QW-1] ? -fin_q : fin_q);
    fin_s   = sat(fin_v);
    fin_ovf = fin_v > SMAX || fin_v < SMIN;
  end

  lrk_div3 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_in),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign status.div_busy = div_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      h     <= (F + 1)'(RST_H);
      sigma <= (W - 1)'(RST_SIGMA);
      rho   <= (W - 1)'(RST_RHO);
      beta  <= (W - 1)'(RST_BETA);
      sx    <= W'(RST_X);
      sy    <= W'(RST_Y);
      sz    <= W'(RST_Z);
    end else if (cfg_we) begin
      case (cfg_index)
        lrk_pkg::REG_STEP_SIZE: h     <= cfg_data[F:0];
        lrk_pkg::REG_SIGMA:     sigma <= cfg_data[W-2:0];
        lrk_pkg::REG_RHO:       rho   <= cfg_data[W-2:0];
        lrk_pkg::REG_BETA:      beta  <= cfg_data[W-2:0];
        lrk_pkg::REG_START_X:   sx    <= signed'(cfg_data);
        lrk_pkg::REG_START_Y:   sy    <= signed'(cfg_data);
        lrk_pkg::REG_START_Z:   sz    <= signed'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // multiplier pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      op1 <= '0;
      op2 <= '0;
    end else begin
      op1 <= cmd.op;
      op2 <= op1;
    end
    prod <= a * b;
    q    <= q_next;
  end

  // point, stage and accumulator state
  always_ff @(posedge clk) begin
    if (rst) begin
      px   <= W'(RST_X);
      py   <= W'(RST_Y);
      pz   <= W'(RST_Z);
      flag <= 1'b0;
    end else begin
      if (cmd.accept) begin
        flag <= 1'b0;
        if (cmd.restart) begin
          px <= sx;
          py <= sy;
          pz <= sz;
          cx <= sx;
          cy <= sy;
          cz <= sz;
        end else begin
          cx    <= px;
          cy    <= py;
          cz    <= pz;
          ex    <= px;
          ey    <= py;
          ez    <= pz;
          acc_x <= '0;
          acc_y <= '0;
          acc_z <= '0;
        end
      end else if (mclip || wb_ovf || (cmd.pos_wr && fin_ovf)) begin
        flag <= 1'b1;
      end

      case (cmd.op.kind)
        lrk_pkg::K_SX: acc_x <= acc_x + (cmd.op.dbl ? AW'(kx) <<< 1 : AW'(kx));
        lrk_pkg::K_SY: acc_y <= acc_y + (cmd.op.dbl ? AW'(ky) <<< 1 : AW'(ky));
        lrk_pkg::K_SZ: acc_z <= acc_z + (cmd.op.dbl ? AW'(kz) <<< 1 : AW'(kz));
        default: begin
        end
      endcase

      case (op2.kind)
        lrk_pkg::K_FX: kx <= wb_s;
        lrk_pkg::K_FY: ky <= wb_s;
        lrk_pkg::K_XY: t  <= q;
        lrk_pkg::K_BZ: kz <= wb_s;
        lrk_pkg::K_SX: ex <= wb_s;
        lrk_pkg::K_SY: ey <= wb_s;
        lrk_pkg::K_SZ: ez <= wb_s;
        lrk_pkg::K_GX: mx <= q;
        lrk_pkg::K_GY: my <= q;
        lrk_pkg::K_GZ: mz <= q;
        default: begin
        end
      endcase

      if (cmd.pos_wr) begin
        case (cmd.op.kind)
          lrk_pkg::K_DY: py <= fin_s;
          lrk_pkg::K_DZ: pz <= fin_s;
          default:       px <= fin_s;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      point_x   <= cx;
      point_y   <= cy;
      point_z   <= cz;
      saturated <= flag;
    end
  end

endmodule

@@ src/lrk_ctrl.sv @@
`timescale 1ns / 1ps
module lrk_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_restart,
  output logic             req_ready,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output lrk_pkg::cmd_t    cmd,
  input  lrk_pkg::status_t status
);
  lrk_pkg::state_t                state, state_next;
  logic [lrk_pkg::PC_BITS-1:0]    pc, pc_next;
  logic                           out_valid, out_valid_next;
  lrk_pkg::op_t                   cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lrk_pkg::S_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    pc_next        = pc;
    out_valid_next = out_valid;
    cmd            = '0;
    req_ready      = 1'b0;
    cur            = lrk_pkg::PROG[pc];
    if (out_valid && rsp_ready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      lrk_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept  = 1'b1;
          cmd.restart = req_restart;
          pc_next     = '0;
          state_next  = req_restart ? lrk_pkg::S_FIN : lrk_pkg::S_RUN;
        end
      end
      lrk_pkg::S_RUN: begin
        cmd.op = cur;
        case (cur.kind)
          lrk_pkg::K_DX, lrk_pkg::K_DY, lrk_pkg::K_DZ: begin
            cmd.div_start = 1'b1;
            state_next    = lrk_pkg::S_DIVWAIT;
          end
          lrk_pkg::K_END: begin
            state_next = lrk_pkg::S_FIN;
          end
          default: begin
            pc_next = pc + 1'b1;
          end
        endcase
      end
      lrk_pkg::S_DIVWAIT: begin
        cmd.op = cur;
        if (!status.div_busy) begin
          cmd.pos_wr = 1'b1;
          pc_next    = pc + 1'b1;
          state_next = lrk_pkg::S_RUN;
        end
      end
      lrk_pkg::S_FIN: begin
        if (!out_valid || rsp_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = lrk_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lrk_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp_valid = out_valid;

  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> status.div_busy)
    else $error("divider not busy after start");

  a_restart_skips: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && cmd.restart) |=> state == lrk_pkg::S_FIN)
    else $error("restart transaction did not go straight to output");

  a_divwait_op: assert property (@(posedge clk) disable iff (rst)
    state == lrk_pkg::S_DIVWAIT |-> (cur.kind == lrk_pkg::K_DX ||
      cur.kind == lrk_pkg::K_DY || cur.kind == lrk_pkg::K_DZ))
    else $error("divide wait on a non-divide step");

endmodule

@@ src/lorenz_rk4_step.sv @@
`timescale 1ns / 1ps
// Lorenz system integrator: holds a Q(WORD_BITS-FRAC_BITS).FRAC_BITS point and, per request,
// either reloads the start point and returns it, or returns the current point and advances it
// by one coupled RK4 step, with a flag for any saturation in that step. One request is worked
// at a time; a restart goes straight to the output register, while a step runs a sequence of
// operations on the single shared multiplier (three stage pipeline) and three divide-by-six
// passes through a divider that retires 6 bits per cycle. A finished result sits in an output
// register, so the next request is taken while it waits. Configuration writes always
// complete at once and are meant to be made while no request is in flight.
module lorenz_rk4_step #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 22
) (
  input logic        clk,
  input logic        rst,
  lrk_req_if.sink    req,
  lrk_rsp_if.source  rsp,
  lrk_cfg_if.sink    cfg
);
  lrk_pkg::cmd_t    cmd;
  lrk_pkg::status_t status;

  assign cfg.ready = 1'b1;

  lrk_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_restart (req.restart),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .cmd         (cmd),
    .status      (status)
  );

  lrk_dp #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .point_x   (rsp.point_x),
    .point_y   (rsp.point_y),
    .point_z   (rsp.point_z),
    .saturated (rsp.saturated)
  );

endmodule
